// File: src/string_escape_decoder_top_defines.svh
// assertion macros for the string escape decoder top level
// no dependencies; included by the top level only
`ifndef STRING_ESCAPE_DECODER_TOP_DEFINES_SVH
`define STRING_ESCAPE_DECODER_TOP_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define SED_ASSERT_NOW(label, clk, rst_n, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define SED_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);

`endif

// File: src/sed_pkg.sv
// shared types and constants of the string escape decoder
// no dependencies; used by sed_decode, sed_out_fifo and the top level
package sed_pkg;

  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned PTR_W     = $clog2(OUT_DEPTH);
  localparam int unsigned LVL_W     = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic [15:0] byte_count;
    logic        is_end;
    logic [7:0]  out_byte;
  } result_t;

  // up to two results produced by one character, in order
  typedef struct packed {
    logic [1:0]       n;
    result_t [1:0]    res;
  } push_t;

endpackage

// File: src/sed_decode.sv
// input register, escape state and per-character decode logic
// depends on sed_pkg
module sed_decode (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_char,
  input  logic                room,
  output sed_pkg::push_t      push
);

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_OCT   = 2'd2,
    MODE_HEX   = 2'd3
  } mode_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_F = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;

  logic [7:0]  char_r;
  logic        full_r;
  mode_t       mode_r, mode_nxt;
  logic [8:0]  acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [15:0] emit_r, emit_nxt;

  logic        fire;
  logic [1:0]  n_c;
  sed_pkg::result_t [1:0] res_c;
  logic        hex_ok;
  logic [3:0]  hex_val;
  logic        oct_ok;

  assign fire      = full_r && room;
  assign in_tready = !full_r || room;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (char_r inside {[CH_ZERO:CH_NINE]}) begin
      hex_val = char_r[3:0];
    end else if (char_r inside {[CH_LOW_A:CH_LOW_F], [CH_UP_A:CH_UP_F]}) begin
      hex_val = char_r[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign oct_ok = char_r inside {[CH_ZERO:CH_SEVEN]};

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    emit_nxt = emit_r;
    n_c      = 2'd0;
    res_c    = '0;
    if (char_r == CH_NUL) begin
      if (mode_r == MODE_OCT || mode_r == MODE_HEX) begin
        emit_nxt            = emit_nxt + 16'd1;
        res_c[0].out_byte   = acc_r[7:0];
        res_c[0].byte_count = emit_nxt;
        n_c                 = 2'd1;
      end
      res_c[n_c[0]].out_byte   = 8'd0;
      res_c[n_c[0]].is_end     = 1'b1;
      res_c[n_c[0]].byte_count = emit_nxt;
      n_c      = n_c + 2'd1;
      mode_nxt = MODE_PLAIN;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      emit_nxt = '0;
    end else begin
      // a digit run broken by another character emits its value first
      if ((mode_r == MODE_OCT && !(oct_ok && cnt_r < 2'd3)) ||
          (mode_r == MODE_HEX && !(hex_ok && cnt_r < 2'd2))) begin
        emit_nxt            = emit_nxt + 16'd1;
        res_c[0].out_byte   = acc_r[7:0];
        res_c[0].byte_count = emit_nxt;
        n_c                 = 2'd1;
        acc_nxt             = '0;
        cnt_nxt             = '0;
        mode_nxt            = MODE_PLAIN;
      end
      case (mode_nxt)
        MODE_PLAIN: begin
          if (char_r == CH_BSL) begin
            mode_nxt = MODE_ESC;
          end else begin
            emit_nxt                 = emit_nxt + 16'd1;
            res_c[n_c[0]].out_byte   = char_r;
            res_c[n_c[0]].byte_count = emit_nxt;
            n_c                      = n_c + 2'd1;
          end
        end
        MODE_ESC: begin
          mode_nxt = MODE_PLAIN;
          if (char_r == CH_LX || char_r == CH_UX) begin
            mode_nxt = MODE_HEX;
            acc_nxt  = '0;
            cnt_nxt  = '0;
          end else if (oct_ok) begin
            mode_nxt = MODE_OCT;
            acc_nxt  = {6'd0, char_r[2:0]};
            cnt_nxt  = 2'd1;
          end else begin
            emit_nxt = emit_nxt + 16'd1;
            res_c[0].byte_count = emit_nxt;
            n_c = 2'd1;
            case (char_r)
              CH_A:    res_c[0].out_byte = 8'h07;
              CH_B:    res_c[0].out_byte = 8'h08;
              CH_T:    res_c[0].out_byte = 8'h09;
              CH_N:    res_c[0].out_byte = 8'h0a;
              CH_V:    res_c[0].out_byte = 8'h0b;
              CH_F:    res_c[0].out_byte = 8'h0c;
              CH_R:    res_c[0].out_byte = 8'h0d;
              default: res_c[0].out_byte = char_r;
            endcase
          end
        end
        MODE_OCT: begin
          acc_nxt = {acc_r[5:0], char_r[2:0]};
          cnt_nxt = cnt_r + 2'd1;
          if (cnt_nxt == 2'd3) begin
            emit_nxt            = emit_nxt + 16'd1;
            res_c[0].out_byte   = acc_nxt[7:0];
            res_c[0].byte_count = emit_nxt;
            n_c                 = 2'd1;
            mode_nxt            = MODE_PLAIN;
            acc_nxt             = '0;
            cnt_nxt             = '0;
          end
        end
        MODE_HEX: begin
          acc_nxt = {acc_r[4:0], hex_val};
          cnt_nxt = cnt_r + 2'd1;
          if (cnt_nxt == 2'd2) begin
            emit_nxt            = emit_nxt + 16'd1;
            res_c[0].out_byte   = acc_nxt[7:0];
            res_c[0].byte_count = emit_nxt;
            n_c                 = 2'd1;
            mode_nxt            = MODE_PLAIN;
            acc_nxt             = '0;
            cnt_nxt             = '0;
          end
        end
        default: mode_nxt = MODE_PLAIN;
      endcase
    end
  end

  always_comb begin
    push.n   = fire ? n_c : 2'd0;
    push.res = res_c;
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      char_r <= in_char;
    end
    if (!rst_n) begin
      full_r <= 1'b0;
      mode_r <= MODE_PLAIN;
      acc_r  <= '0;
      cnt_r  <= '0;
      emit_r <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        full_r <= 1'b1;
      end else if (fire) begin
        full_r <= 1'b0;
      end
      if (fire) begin
        mode_r <= mode_nxt;
        acc_r  <= acc_nxt;
        cnt_r  <= cnt_nxt;
        emit_r <= emit_nxt;
      end
    end
  end

endmodule

// File: src/sed_out_fifo.sv
// result queue: takes up to two results a cycle, hands out one a cycle while out_tready is high
// depends on sed_pkg
module sed_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  sed_pkg::push_t      push,
  output logic                room,
  output logic                out_tvalid,
  input  logic                out_tready,
  output sed_pkg::result_t    out_res
);

  sed_pkg::result_t [sed_pkg::OUT_DEPTH-1:0] mem_r;
  logic [sed_pkg::PTR_W-1:0] wp_r, rp_r;
  logic [sed_pkg::LVL_W-1:0] lvl_r;
  logic                      pop;
  logic [sed_pkg::PTR_W-1:0] wp_inc;

  localparam logic [sed_pkg::LVL_W-1:0] RoomMax = sed_pkg::LVL_W'(sed_pkg::OUT_DEPTH - 2);

  assign room       = lvl_r <= RoomMax;
  assign out_tvalid = lvl_r != '0;
  assign out_res    = mem_r[rp_r];
  assign pop        = out_tvalid && out_tready;
  assign wp_inc     = wp_r + sed_pkg::PTR_W'(1);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wp_r] <= push.res[0];
    end
    if (push.n == 2'd2) begin
      mem_r[wp_inc] <= push.res[1];
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      lvl_r <= '0;
    end else begin
      wp_r  <= wp_r + sed_pkg::PTR_W'(push.n);
      if (pop) begin
        rp_r <= rp_r + sed_pkg::PTR_W'(1);
      end
      lvl_r <= lvl_r + sed_pkg::LVL_W'(push.n) - sed_pkg::LVL_W'(pop);
    end
  end

endmodule

// File: src/string_escape_decoder_top.sv
// String escape decoder: one source character per beat in, decoded bytes out.
// A character is registered on entry and decoded from that register into at most
// two results (a pending octal or hex value plus the character's own byte,
// or a pending value plus the end-of-string beat), which go into a
// four-entry result queue. The input side takes one character per cycle
// whenever the queue has room for two results; the output side gives one
// result per cycle while out_tready is high, so a character that yields two
// results leaves as two output beats. The first result passes through the
// input register and the result queue before it is valid.
// A zero character closes the string with a tlast beat carrying the count.
// depends on sed_pkg, sed_decode, sed_out_fifo, string_escape_decoder_top_defines.svh
`include "string_escape_decoder_top_defines.svh"

module string_escape_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] in_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [7:0] out_byte, [23:8] byte_count
  output logic        out_tlast
);

  sed_pkg::push_t   push;
  sed_pkg::result_t out_res;
  logic             room;

  sed_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_char   (in_tdata),
    .room      (room),
    .push      (push)
  );

  sed_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {out_res.byte_count, out_res.out_byte};
  assign out_tlast = out_res.is_end;

  `SED_ASSERT_NOW(a_push_room, clk, rst_n, push.n != 2'd0, room, "push without queue room")
  `SED_ASSERT_NOW(a_end_last, clk, rst_n, push.n == 2'd2, !push.res[0].is_end, "end beat not last of pair")
  `SED_ASSERT_NOW(a_end_zero, clk, rst_n, out_tvalid && out_tlast, out_tdata[7:0] == 8'd0, "end beat with nonzero byte")

endmodule
